FILE: hw/rtl/cpu_process_scheduler_core_assert.svh
// assertion macros for the cpu process scheduler
// no dependencies; empty bodies when SYNTH is defined
`ifndef CPU_PROCESS_SCHEDULER_CORE_ASSERT_SVH
`define CPU_PROCESS_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTH
`define CPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: hw/rtl/cps_pkg.sv
// shared types and codes for the cpu process scheduler
// no dependencies
package cps_pkg;
  localparam logic [2:0] MODE_FCFS  = 3'd0;
  localparam logic [2:0] MODE_SJF   = 3'd1;
  localparam logic [2:0] MODE_PRI   = 3'd2;
  localparam logic [2:0] MODE_RR    = 3'd3;
  localparam logic [2:0] MODE_PSJF  = 3'd4;
  localparam logic [2:0] MODE_PPRI  = 3'd5;

  localparam logic [1:0] ST_LOADED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RAN    = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [0:0] REG_MODE    = 1'd0;
  localparam logic [0:0] REG_QUANTUM = 1'd1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  proc_id;
    logic [15:0] arrive_at;
    logic [13:0] burst_len;
    logic [13:0] prio_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  run_id;
    logic        finished;
    logic [7:0]  finished_id;
    logic [15:0] turnaround;
    logic [15:0] wait_time;
    logic        all_done;
  } rsp_t;
endpackage

FILE: hw/rtl/cps_stream_if.sv
// valid/ready channel carrying one payload type
// no dependencies; the payload type is a parameter
interface cps_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cpu_process_scheduler_core.sv
// cpu process scheduler: a load goes from idle to S_OUT, which registers its result;
// a tick goes through S_SCAN (a read of every table slot, each compared as it returns),
// then S_EXEC (a read of the selected entry, then the update) and then S_OUT.
// one request at a time; the next request is taken on the edge that takes the result,
// and a result not taken blocks the input. async active-low reset clears counters
// and hold and sets config to its defaults; table contents are undefined until loaded
`include "cpu_process_scheduler_core_assert.svh"
module cpu_process_scheduler_core #(
  parameter int MAX_PROCS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  cps_stream_if.sink   req_i,
  cps_stream_if.source rsp_o
);
  import cps_pkg::*;

  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // table memory (one write, one read port per field group)
  logic [7:0]  tab_id   [MAX_PROCS];
  logic [15:0] tab_arr  [MAX_PROCS];
  logic [13:0] tab_bur  [MAX_PROCS];
  logic [13:0] tab_rem  [MAX_PROCS];
  logic [13:0] tab_pri  [MAX_PROCS];

  logic [1:0]    state_q, state_d;
  logic [2:0]    mode_q;
  logic [7:0]    quantum_q;
  logic [CW-1:0] loaded_q, completed_q;
  logic [15:0]   now_q;
  logic [SW-1:0] holder_q;
  logic          hvalid_q;
  logic [7:0]    slice_q;
  logic [SW-1:0] rrnext_q;
  rsp_t          rsp_q;
  logic          rsp_valid_q;

  // scan sequencer
  logic [CW-1:0] cnt_q;        // scan steps issued
  logic [SW-1:0] rd_addr;
  logic          rd_vld_q;     // registered read is valid
  logic [SW-1:0] rd_slot_q;
  logic [7:0]    rd_id_q;
  logic [15:0]   rd_arr_q, rd_bur_q_16;
  logic [13:0]   rd_bur_q, rd_rem_q, rd_pri_q;
  logic          best_v_q;
  logic [SW-1:0] best_q;
  logic [13:0]   bestval_q;
  logic          hold_ok_q;    // holder seen eligible during scan
  logic [2:0]    emode;
  // the exec step needs the selected entry; a final read cycle fetches it
  logic          exec_rd_q;

  assign rd_bur_q_16 = {2'b00, rd_bur_q};

  always_comb begin
    emode = (mode_q > MODE_PPRI) ? MODE_FCFS : mode_q;
  end

  // scan address: rr scans circularly from rrnext, others from zero
  logic [SW:0] rr_sum;
  always_comb begin
    rr_sum = {1'b0, rrnext_q} + {1'b0, cnt_q[SW-1:0]};
    if (emode == MODE_RR) begin
      rd_addr = (rr_sum >= (SW+1)'(MAX_PROCS)) ? SW'(rr_sum - (SW+1)'(MAX_PROCS))
                                                : rr_sum[SW-1:0];
    end else begin
      rd_addr = cnt_q[SW-1:0];
    end
  end

  logic        rd_elig;
  logic [13:0] rd_key;
  assign rd_elig = rd_vld_q && ({1'b0, rd_slot_q} < (SW+1)'(loaded_q))
                   && (rd_arr_q <= now_q) && (rd_rem_q != 14'd0);
  always_comb begin
    case (emode)
      MODE_SJF, MODE_PSJF: rd_key = rd_rem_q;
      MODE_PRI, MODE_PPRI: rd_key = rd_pri_q;
      default:             rd_key = 14'd0;
    endcase
  end

  // exec step decisions
  logic          preempt;
  logic          use_hold;
  logic          sel_v;
  logic [SW-1:0] sel;
  assign preempt  = (emode == MODE_PSJF) || (emode == MODE_PPRI);
  assign use_hold = !preempt && hvalid_q && hold_ok_q;
  assign sel_v    = use_hold || best_v_q;
  assign sel      = use_hold ? holder_q : best_q;

  logic [7:0]  q_eff;
  assign q_eff = (quantum_q == 8'd0) ? 8'd1 : quantum_q;

  logic [13:0] new_rem;
  logic [15:0] now_inc, ta;
  logic [7:0]  slice_base, slice_inc;
  logic [SW-1:0] sel_next;
  assign new_rem = rd_rem_q - 14'd1;
  assign now_inc = now_q + 16'd1;
  assign ta = now_inc - rd_arr_q;
  assign slice_base = (use_hold) ? slice_q : 8'd0;
  assign slice_inc = (slice_base == 8'd255) ? slice_base : slice_base + 8'd1;
  assign sel_next = ({1'b0, sel} == (SW+1)'(MAX_PROCS - 1)) ? '0 : SW'(sel + SW'(1));

  // result words for a load and for a tick
  rsp_t load_rsp;
  rsp_t exec_rsp;
  always_comb begin
    load_rsp = '0;
    load_rsp.status = (loaded_q < CW'(MAX_PROCS)) ? ST_LOADED : ST_FULL;
  end

  always_comb begin
    exec_rsp = '0;
    if (!sel_v) begin
      exec_rsp.status = ST_IDLE;
    end else begin
      exec_rsp.status = ST_RAN;
      exec_rsp.run_id = rd_id_q;
      if (new_rem == 14'd0) begin
        exec_rsp.finished    = 1'b1;
        exec_rsp.finished_id = rd_id_q;
        exec_rsp.turnaround  = ta;
        exec_rsp.wait_time   = ta - rd_bur_q_16;
      end
    end
  end

  assign req_i.ready = (state_q == S_IDLE) && !(rsp_valid_q && !rsp_o.ready);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  logic in_fire;
  assign in_fire = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = (req_i.data.operation == OP_TICK) ? S_SCAN : S_OUT;
      S_SCAN: if (cnt_q == CW'(MAX_PROCS) && !rd_vld_q) state_d = S_EXEC;
      S_EXEC: if (exec_rd_q) state_d = S_OUT;
      S_OUT:  if (!rsp_valid_q || rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // table writes and registered read
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [13:0]   wr_rem;
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_fire && req_i.data.operation == OP_LOAD
        && loaded_q < CW'(MAX_PROCS)) begin
      tab_id[loaded_q[SW-1:0]]  <= req_i.data.proc_id;
      tab_arr[loaded_q[SW-1:0]] <= req_i.data.arrive_at;
      tab_bur[loaded_q[SW-1:0]] <= req_i.data.burst_len;
      tab_pri[loaded_q[SW-1:0]] <= req_i.data.prio_value;
    end
    if (wr_en) tab_rem[wr_addr] <= wr_rem;
    rd_id_q  <= tab_id[(state_q == S_SCAN) ? rd_addr : sel];
    rd_arr_q <= tab_arr[(state_q == S_SCAN) ? rd_addr : sel];
    rd_bur_q <= tab_bur[(state_q == S_SCAN) ? rd_addr : sel];
    rd_rem_q <= tab_rem[(state_q == S_SCAN) ? rd_addr : sel];
    rd_pri_q <= tab_pri[(state_q == S_SCAN) ? rd_addr : sel];
    rd_slot_q <= (state_q == S_SCAN) ? rd_addr : sel;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = loaded_q[SW-1:0];
    wr_rem = req_i.data.burst_len;
    if (state_q == S_IDLE && in_fire && req_i.data.operation == OP_LOAD
        && loaded_q < CW'(MAX_PROCS)) begin
      wr_en = 1'b1;
    end else if (state_q == S_EXEC && exec_rd_q && sel_v) begin
      wr_en = 1'b1;
      wr_addr = sel;
      wr_rem = new_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_FCFS;
      quantum_q <= 8'd4;
      loaded_q <= '0;
      completed_q <= '0;
      now_q <= '0;
      holder_q <= '0;
      hvalid_q <= 1'b0;
      slice_q <= '0;
      rrnext_q <= '0;
      rsp_q <= '0;
      rsp_valid_q <= 1'b0;
      cnt_q <= '0;
      rd_vld_q <= 1'b0;
      best_v_q <= 1'b0;
      best_q <= '0;
      bestval_q <= '0;
      hold_ok_q <= 1'b0;
      exec_rd_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE) mode_q <= cfg_data_i[2:0];
        else if (cfg_idx_i == REG_QUANTUM) quantum_q <= cfg_data_i;
      end
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cnt_q <= '0;
            rd_vld_q <= 1'b0;
            best_v_q <= 1'b0;
            hold_ok_q <= 1'b0;
            exec_rd_q <= 1'b0;
            if (req_i.data.operation == OP_LOAD) begin
              rsp_q <= load_rsp;
              if (loaded_q < CW'(MAX_PROCS)) begin
                loaded_q <= loaded_q + CW'(1);
                if (req_i.data.burst_len == 14'd0) completed_q <= completed_q + CW'(1);
              end
            end
          end
        end
        S_SCAN: begin
          // issue one read per cycle, compare the previous one
          if (cnt_q != CW'(MAX_PROCS)) begin
            cnt_q <= cnt_q + CW'(1);
            rd_vld_q <= 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_elig) begin
            if (!best_v_q || rd_key < bestval_q) begin
              best_v_q <= 1'b1;
              best_q <= rd_slot_q;
              bestval_q <= rd_key;
            end
            if (rd_slot_q == holder_q) hold_ok_q <= 1'b1;
          end
        end
        S_EXEC: begin
          // first cycle in exec only waits for the selected entry's read
          if (!exec_rd_q) begin
            exec_rd_q <= 1'b1;
          end else begin
            now_q <= now_inc;
            rsp_q <= exec_rsp;
            if (!sel_v) begin
              if (preempt || !hold_ok_q) hvalid_q <= 1'b0;
            end else begin
              holder_q <= sel;
              // completion or an expired rr slice releases the hold
              if (new_rem == 14'd0 || (emode == MODE_RR && slice_inc >= q_eff)) begin
                hvalid_q <= 1'b0;
                slice_q <= '0;
                rrnext_q <= sel_next;
              end else begin
                hvalid_q <= !preempt;
                slice_q <= slice_inc;
              end
              if (new_rem == 14'd0) completed_q <= completed_q + CW'(1);
            end
          end
        end
        S_OUT: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_q.all_done <= (completed_q == loaded_q);
          end
        end
        default: ;
      endcase
    end
  end

  // in S_OUT all_done is taken from the counters after the update
  `CPS_ASSERT(a_ready_idle, clk_i, rst_ni, !req_i.ready || state_q == S_IDLE, "ready outside idle")
  `CPS_ASSERT(a_count_order, clk_i, rst_ni, completed_q <= loaded_q, "completed above loaded")
  `CPS_ASSERT_NEXT(a_scan_bound, clk_i, rst_ni, state_q == S_SCAN, cnt_q <= CW'(MAX_PROCS), "scan overrun")
endmodule
